// ===== rtl/exp2pa_pkg.sv =====
// shared types and constants for the exp2 polynomial approximation pipeline
`default_nettype none
package exp2pa_pkg;

    // fraction width of the polynomial argument and of the coefficients
    localparam int Q_BITS = 30;

    // field widths
    localparam int X_W      = 44;
    localparam int POWER_W  = 12;
    localparam int FACTOR_W = 32;
    localparam int PROD_W   = FACTOR_W + Q_BITS;

    // exponent clamp bounds, integer part
    localparam int CLAMP_HI = 1025;
    localparam int CLAMP_LO = 1023;

    // minimax coefficients in Q2.30, row = degree - 2, column = power of the fraction
    localparam logic [FACTOR_W-1:0] COEF_TAB [0:3][0:5] = '{
        '{32'd1075593707, 32'd706131579, 32'd362054404, 32'd0, 32'd0, 32'd0},
        '{32'd1073661508, 32'd747145596, 32'd242737765, 32'd83778191, 32'd0, 32'd0},
        '{32'd1073744616, 32'd744107196, 32'd259247179, 32'd55846884, 32'd14532201,
          32'd0},
        '{32'd1073741760, 32'd744267452, 32'd257862975, 32'd59943053, 32'd9652230,
          32'd2016033}
    };

    // side information that travels with each item down the pipeline
    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic               clamped;
        logic [Q_BITS-1:0]  frac;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/exp2_poly_approximation.sv =====
// Usage notes for the exp2 polynomial approximation block.
// The slave stream carries one exponent x per transaction in s_tdata (signed, FRAC_BITS
// fraction bits). The master stream returns power and factor in m_tdata and the clamp flag
// in m_tuser, one result transaction per input transaction, in order.
// The result approximates 2^x as factor * 2^power, factor in unsigned Q2.30.
// x outside [-1023, 1025] is clamped to the nearest bound and flagged.
// Pipeline: from the accepting edge to m_tvalid an item passes through
// 1 + 2 * degree register stages: one stage clamps and splits x, then each Horner step
// takes a multiply stage and an add stage, one 32x30 multiplier per step.
// Throughput: one transaction per cycle sustained while m_tready stays high; every stage carries its own valid bit.
// When m_tready is low the stages fill up behind the output register; bubbles are
// squeezed out, and s_tready drops only once every stage holds an item.
// Nothing is lost or repeated across a stall.
// Reset (rst_n low, asynchronous) empties the pipeline; no result is pending afterwards.
`default_nettype none
module exp2_poly_approximation
    import exp2pa_pkg::*;
#(
    parameter int FRAC_BITS   = 32,
    parameter int POLY_DEGREE = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [43:0] x_value, [47:44] zero
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [11:0] power, [43:12] factor, [47:44] zero
    output logic             m_tuser    // [0] clamped
);

    // supported degree and pipeline depth
    localparam int DEG = (POLY_DEGREE < 2) ? 2 : ((POLY_DEGREE > 5) ? 5 : POLY_DEGREE);
    localparam int ROW = DEG - 2;
    localparam int NST = 1 + 2 * DEG;

    // compare width wide enough for the input and for both bounds
    localparam int CMP_W = (X_W > FRAC_BITS + POWER_W) ? X_W + 1 : FRAC_BITS + POWER_W + 1;
    localparam logic signed [CMP_W-1:0] HI_BOUND = CMP_W'(CLAMP_HI) << FRAC_BITS;
    localparam logic signed [CMP_W-1:0] LO_BOUND = -(CMP_W'(CLAMP_LO) << FRAC_BITS);

    logic [NST-1:0]    valid_reg;
    logic [NST-1:0]    valid_next;
    logic [NST:0]      load;
    logic [PROD_W-1:0] data_reg  [NST];
    logic [PROD_W-1:0] data_next [NST];
    side_t             side_reg  [NST];
    side_t             side_next [NST];

    logic signed [X_W-1:0]   x_value;
    logic signed [CMP_W-1:0] x_ext;
    logic signed [CMP_W-1:0] x_clamp;
    logic                    x_clamped;
    logic [Q_BITS-1:0]       x_frac;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        load[NST] = m_tready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end
    assign s_tready = load[0];

    // clamp to the bound interval
    assign x_value = s_tdata[X_W-1:0];
    assign x_ext   = {{(CMP_W-X_W){x_value[X_W-1]}}, x_value};
    always_comb
    begin
        x_clamp   = x_ext;
        x_clamped = 1'b0;
        if (x_ext < LO_BOUND)
        begin
            x_clamp   = LO_BOUND;
            x_clamped = 1'b1;
        end
        else if (x_ext > HI_BOUND)
        begin
            x_clamp   = HI_BOUND;
            x_clamped = 1'b1;
        end
    end

    // bring the fraction to Q0.30
    generate
        if (FRAC_BITS >= Q_BITS)
        begin : g_frac_trunc
            assign x_frac = x_clamp[FRAC_BITS-1 -: Q_BITS];
        end
        else
        begin : g_frac_fill
            assign x_frac = {x_clamp[FRAC_BITS-1:0], {(Q_BITS-FRAC_BITS){1'b0}}};
        end
    endgenerate

    // split stage: floor as power, leading coefficient as start value
    always_comb
    begin
        side_next[0].power   = x_clamp[FRAC_BITS +: POWER_W];
        side_next[0].clamped = x_clamped;
        side_next[0].frac    = x_frac;
        data_next[0]         = PROD_W'(COEF_TAB[ROW][DEG]);
    end

    // horner steps: multiply stage then add stage
    generate
        for (genvar j = 1; j <= DEG; j++)
        begin : g_step
            logic [FACTOR_W:0] sum;

            // product of accumulator and fraction, full width
            always_comb
            begin
                side_next[2*j-1] = side_reg[2*j-2];
                data_next[2*j-1] = {{Q_BITS{1'b0}}, data_reg[2*j-2][FACTOR_W-1:0]}
                                 * {{FACTOR_W{1'b0}}, side_reg[2*j-2].frac};
            end

            // truncate the product and add the next coefficient, saturating
            assign sum = {1'b0, data_reg[2*j-1][PROD_W-1:Q_BITS]}
                       + {1'b0, COEF_TAB[ROW][DEG-j]};
            always_comb
            begin
                side_next[2*j] = side_reg[2*j-1];
                data_next[2*j] = {{Q_BITS{1'b0}},
                                  sum[FACTOR_W] ? {FACTOR_W{1'b1}} : sum[FACTOR_W-1:0]};
            end
        end
    endgenerate

    // valid bits follow the data
    always_comb
    begin
        valid_next[0] = load[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (load[i])
            begin
                data_reg[i] <= data_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    // output stream
    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = {4'b0, data_reg[NST-1][FACTOR_W-1:0], side_reg[NST-1].power};
    assign m_tuser  = side_reg[NST-1].clamped;

    // full pipeline is the only reason to refuse input
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input refused while pipeline has room");

    // power stays within the clamp interval
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[11:0]) >= -12'sd1023
                      && $signed(m_tdata[11:0]) <= 12'sd1025))
        else $error("power outside clamp interval");

    // a clamped item sits on a bound with zero fraction
    a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata[11:0] == 12'(-CLAMP_LO)
                                    || m_tdata[11:0] == 12'(CLAMP_HI))
                                   && m_tdata[43:12] == COEF_TAB[ROW][0]))
        else $error("clamped result not at a bound");

    // a result never appears out of an empty pipeline
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |=> !m_tvalid)
        else $error("result appeared out of an empty pipeline");

endmodule
`default_nettype wire

// ===== dv/exp2_result_checker.sv =====
// result checker for the exp2 approximation block: predicts each result and compares it
`timescale 1ns / 1ps

module exp2_result_checker
    import exp2pa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // [43:0] x_value, [47:44] zero
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // [11:0] power, [43:12] factor, [47:44] zero
    input  wire logic        m_tuser,   // [0] clamped
    output int               mismatch_count,
    output int               results_pending
);

    // fixed-point setup of the block as instantiated
    localparam int FRAC_BITS  = 32;
    localparam int ARG_FRAC   = 30;
    localparam longint X_UPPER_INT = 1025;
    localparam longint X_LOWER_INT = -1023;

    // degree-5 minimax coefficients of 2^f in Q2.30, index = power of f
    localparam logic [63:0] HORNER_COEF [0:5] = '{
        64'd1073741760, 64'd744267452, 64'd257862975,
        64'd59943053, 64'd9652230, 64'd2016033
    };

    typedef struct packed {
        logic [POWER_W-1:0]  power;
        logic [FACTOR_W-1:0] factor;
        logic                clamped;
    } exp2_result_t;

    exp2_result_t expected_results[$];

    // clamp, split into floor and fraction, then evaluate the polynomial by Horner steps
    function automatic exp2_result_t predict_exp2(logic [X_W-1:0] x_bits);
        longint       x_val;
        longint       x_upper;
        longint       x_lower;
        longint       offset;
        longint       power_full;
        logic [63:0]  frac;
        logic [63:0]  acc;
        exp2_result_t res;
        x_val   = {{(64 - X_W){x_bits[X_W-1]}}, x_bits};
        x_upper = X_UPPER_INT <<< FRAC_BITS;
        x_lower = X_LOWER_INT <<< FRAC_BITS;
        res.clamped = 1'b0;
        if (x_val < x_lower)
        begin
            x_val = x_lower;
            res.clamped = 1'b1;
        end
        if (x_val > x_upper)
        begin
            x_val = x_upper;
            res.clamped = 1'b1;
        end
        // offset from the lower bound is never negative, so the shift is a true floor
        offset     = x_val - x_lower;
        power_full = (offset >>> FRAC_BITS) + X_LOWER_INT;
        res.power  = power_full[POWER_W-1:0];
        frac = 64'(offset) & ((64'd1 << FRAC_BITS) - 64'd1);
        if (FRAC_BITS >= ARG_FRAC)
            frac = frac >> (FRAC_BITS - ARG_FRAC);
        else
            frac = frac << (ARG_FRAC - FRAC_BITS);
        // truncating multiply, then add the next coefficient
        acc = HORNER_COEF[5];
        for (int k = 4; k >= 0; k--)
            acc = ((acc * frac) >> ARG_FRAC) + HORNER_COEF[k];
        if (acc > 64'hFFFF_FFFF)
            acc = 64'hFFFF_FFFF;
        res.factor = acc[FACTOR_W-1:0];
        return res;
    endfunction

    // watch both channels: queue predictions on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        exp2_result_t exp_r;
        exp2_result_t got_r;
        if (!rst_n)
        begin
            expected_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_exp2(s_tdata[X_W-1:0]));
            if (m_tvalid && m_tready)
            begin
                got_r.power   = m_tdata[POWER_W-1:0];
                got_r.factor  = m_tdata[POWER_W +: FACTOR_W];
                got_r.clamped = m_tuser;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expected result: power %0d factor %0h",
                           $signed(got_r.power), got_r.factor);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.power !== exp_r.power)
                    begin
                        $error("power: expected %0d, got %0d",
                               $signed(exp_r.power), $signed(got_r.power));
                        mismatch_count++;
                    end
                    if (got_r.factor !== exp_r.factor)
                    begin
                        $error("factor: expected %08h, got %08h", exp_r.factor, got_r.factor);
                        mismatch_count++;
                    end
                    if (got_r.clamped !== exp_r.clamped)
                    begin
                        $error("clamped: expected %0b, got %0b", exp_r.clamped, got_r.clamped);
                        mismatch_count++;
                    end
                end
            end
            results_pending = expected_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for the exp2 approximation block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
    import exp2pa_pkg::*;

    localparam int RANDOM_ITEMS = 1430;
    localparam int DRAIN_CYCLES = 40;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    int          mismatch_count;
    int          results_pending;

    int          burst_left = 1;
    int          ready_mode = 0;
    int          ready_cycle = 0;

    exp2_poly_approximation #(
        .FRAC_BITS   (32),
        .POLY_DEGREE (5)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    exp2_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver back-pressure, with the mode drawn at random from four
    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 200 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (ready_cycle % 7 < 4);
            default: m_tready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // exponent from a signed integer part and a 32-bit fraction
    function automatic logic [X_W-1:0] make_x(longint int_part, longint frac_part);
        longint v;
        v = (int_part <<< 32) + frac_part;
        return v[X_W-1:0];
    endfunction

    // one transaction on the slave side, then at the end of a burst possibly a random gap
    task automatic send_x(logic [X_W-1:0] x_bits);
        bit took;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(48 - X_W){1'b0}}, x_bits};
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        logic [X_W-1:0] x_bits;
        int             pick;
        longint         bound;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, exact bounds, just past them, negative fractions
        send_x(make_x(0, 0));
        send_x(make_x(0, 1));
        send_x(make_x(-1, 32'hFFFF_FFFF));
        send_x(44'h7FF_FFFF_FFFF);
        send_x(44'h800_0000_0000);
        send_x(make_x(1025, 0));
        send_x(make_x(1025, 1));
        send_x(make_x(1024, 32'hFFFF_FFFF));
        send_x(make_x(-1023, 0));
        send_x(make_x(-1023, 1));
        send_x(make_x(-1024, 32'hFFFF_FFFF));
        send_x(make_x(0, 32'h8000_0000));
        send_x(make_x(-1, 32'h8000_0000));
        send_x(make_x(1, 0));
        send_x(make_x(-1, 0));
        send_x(make_x(0, 32'hFFFF_FFFF));
        send_x(make_x(0, 3));
        send_x(make_x(5, 32'h4000_0000));
        send_x(make_x(-7, 32'hC000_0003));
        send_x(make_x(1000, 32'h1234_5678));
        send_x(make_x(-1000, 32'hABCD_EF01));
        drain_results();

        // random: mostly in range, some near the bounds, the rest anywhere
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                x_bits = make_x(longint'($urandom_range(0, 2048)) - 1023, $urandom());
            else if (pick < 75)
            begin
                bound  = ($urandom_range(0, 1) == 1) ? 1025 : -1023;
                x_bits = make_x(bound, longint'($urandom_range(0, 64)) - 32);
            end
            else
                x_bits = {12'($urandom_range(0, 4095)), 32'($urandom())};
            send_x(x_bits);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/exp2pa_pkg.sv
rtl/exp2_poly_approximation.sv
dv/exp2_result_checker.sv
dv/tb.sv
